// ===== rtl/gfl_pkg.sv =====
// shared constants, codes and pipeline types for the gradient fill line generator
package gfl_pkg;

  localparam int COORD_W    = 16;
  localparam int EXT_W      = 12;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int COLOR_W    = NUM_CH * CH_W;
  localparam int MAX_EXTENT = 4095;
  localparam int QUO_W      = CH_W;
  localparam int NUM_CELLS  = QUO_W;
  localparam int REM_W      = CH_W + EXT_W;
  localparam int DIV_W      = EXT_W + QUO_W - 1;

  typedef enum logic [1:0] {
    DIR_TOP_DOWN   = 2'd0,
    DIR_LEFT_RIGHT = 2'd1,
    DIR_BOTTOM_UP  = 2'd2,
    DIR_RIGHT_LEFT = 2'd3
  } dir_t;

  typedef struct packed {
    logic                                line_ok;
    logic [COORD_W-1:0]                  x0;
    logic [COORD_W-1:0]                  y0;
    logic [COORD_W-1:0]                  x1;
    logic [COORD_W-1:0]                  y1;
    logic [NUM_CH-1:0][CH_W-1:0]         base;
    logic [NUM_CH-1:0]                   neg;
    logic [NUM_CH-1:0][REM_W-1:0]        rem;
    logic [NUM_CH-1:0][QUO_W-1:0]        quo;
    logic [DIV_W-1:0]                    div;
  } stage_t;

endpackage

// ===== rtl/gfl_in_if.sv =====
// input channel: one rectangle and gradient step per beat
interface gfl_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [gfl_pkg::COORD_W-1:0] rect_x;
  logic signed [gfl_pkg::COORD_W-1:0] rect_y;
  logic [gfl_pkg::EXT_W-1:0]          rect_width;
  logic [gfl_pkg::EXT_W-1:0]          rect_height;
  logic [gfl_pkg::COLOR_W-1:0]        start_color;
  logic [gfl_pkg::COLOR_W-1:0]        end_color;
  logic [1:0]                         direction;
  logic [gfl_pkg::EXT_W-1:0]          step_index;

  modport source (output valid, rect_x, rect_y, rect_width, rect_height, start_color,
                  end_color, direction, step_index, input ready);
  modport sink (input valid, rect_x, rect_y, rect_width, rect_height, start_color,
                end_color, direction, step_index, output ready);
endinterface

// ===== rtl/gfl_out_if.sv =====
// output channel: one fill line per beat
interface gfl_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gfl_pkg::COORD_W-1:0] line_x0;
  logic signed [gfl_pkg::COORD_W-1:0] line_y0;
  logic signed [gfl_pkg::COORD_W-1:0] line_x1;
  logic signed [gfl_pkg::COORD_W-1:0] line_y1;
  logic [gfl_pkg::CH_W-1:0]           red_out;
  logic [gfl_pkg::CH_W-1:0]           green_out;
  logic [gfl_pkg::CH_W-1:0]           blue_out;
  logic                               line_valid;

  modport source (output valid, line_x0, line_y0, line_x1, line_y1, red_out, green_out,
                  blue_out, line_valid, input ready);
  modport sink (input valid, line_x0, line_y0, line_x1, line_y1, red_out, green_out,
                blue_out, line_valid, output ready);
endinterface

// ===== rtl/gfl_prep.sv =====
// front stage: line geometry, extent check and colour difference products
module gfl_prep (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  gfl_in_if.sink           item,
  output logic             vld,
  output gfl_pkg::stage_t  st
);

  logic                              vert;
  logic [gfl_pkg::EXT_W-1:0]         ext;
  logic [gfl_pkg::EXT_W-1:0]         row;
  logic [gfl_pkg::EXT_W-1:0]         col;
  logic [gfl_pkg::COORD_W-1:0]       x;
  logic [gfl_pkg::COORD_W-1:0]       y;
  logic [gfl_pkg::COORD_W-1:0]       far_x;
  logic [gfl_pkg::COORD_W-1:0]       far_y;
  logic [gfl_pkg::CH_W-1:0]          ca;
  logic [gfl_pkg::CH_W-1:0]          cb;
  logic [gfl_pkg::CH_W-1:0]          mag;
  gfl_pkg::stage_t                   st_next;

  assign item.ready = en;

  always_comb begin
    ca  = '0;
    cb  = '0;
    mag = '0;
    x     = item.rect_x;
    y     = item.rect_y;
    vert  = (item.direction == gfl_pkg::DIR_TOP_DOWN) ||
            (item.direction == gfl_pkg::DIR_BOTTOM_UP);
    ext   = vert ? item.rect_height : item.rect_width;
    row   = (item.direction == gfl_pkg::DIR_TOP_DOWN) ? item.step_index
          : item.rect_height - 12'd1 - item.step_index;
    col   = (item.direction == gfl_pkg::DIR_LEFT_RIGHT) ? item.step_index
          : item.rect_width - 12'd1 - item.step_index;
    far_x = x + gfl_pkg::COORD_W'(item.rect_width) - 16'd1;
    far_y = y + gfl_pkg::COORD_W'(item.rect_height) - 16'd1;

    st_next.line_ok = (ext != '0) &&
                      ({1'b0, ext} <= (gfl_pkg::EXT_W+1)'(gfl_pkg::MAX_EXTENT)) &&
                      (item.step_index < ext);
    if (vert) begin
      st_next.x0 = x;
      st_next.x1 = far_x;
      st_next.y0 = y + gfl_pkg::COORD_W'(row);
      st_next.y1 = y + gfl_pkg::COORD_W'(row);
    end else begin
      st_next.x0 = x + gfl_pkg::COORD_W'(col);
      st_next.x1 = x + gfl_pkg::COORD_W'(col);
      st_next.y0 = y;
      st_next.y1 = far_y;
    end

    for (int c = 0; c < gfl_pkg::NUM_CH; c++) begin
      ca  = item.start_color[(gfl_pkg::NUM_CH-1-c)*gfl_pkg::CH_W +: gfl_pkg::CH_W];
      cb  = item.end_color[(gfl_pkg::NUM_CH-1-c)*gfl_pkg::CH_W +: gfl_pkg::CH_W];
      mag = (cb < ca) ? ca - cb : cb - ca;
      st_next.base[c] = ca;
      st_next.neg[c]  = cb < ca;
      st_next.rem[c]  = gfl_pkg::REM_W'(mag) * gfl_pkg::REM_W'(item.step_index);
      st_next.quo[c]  = '0;
    end
    st_next.div = {ext, {(gfl_pkg::QUO_W-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

endmodule

// ===== rtl/gfl_cell.sv =====
// one restoring division step for all three channels, passing the line along
module gfl_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_in,
  input  gfl_pkg::stage_t  st_in,
  output logic             vld,
  output gfl_pkg::stage_t  st
);

  gfl_pkg::stage_t st_next;

  always_comb begin
    st_next     = st_in;
    st_next.div = st_in.div >> 1;
    for (int c = 0; c < gfl_pkg::NUM_CH; c++) begin
      if ({1'b0, st_in.div} <= st_in.rem[c]) begin
        st_next.rem[c] = st_in.rem[c] - gfl_pkg::REM_W'(st_in.div);
        st_next.quo[c] = {st_in.quo[c][gfl_pkg::QUO_W-2:0], 1'b1};
      end else begin
        st_next.quo[c] = {st_in.quo[c][gfl_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

endmodule

// ===== rtl/gradient_fill_line_generator.sv =====
// top level: front stage, chain of divider cells and output register
// Usage:
//   item carries one rectangle, two RGB colours, a direction and a step
//   index per beat; line returns one fill line per beat, in order: its
//   endpoints, its colour and line_valid. A line that does not exist (step
//   at or beyond the extent) comes back with line_valid low and all other
//   fields zero.
// Pipeline: front stage, eight divider cells and output register, from
//   the item beat to the line beat. Throughput: one item per cycle when
//   not stalled. Each divider cell settles one quotient bit of all three
//   colour channels and hands the line on to the next cell.
// Stall: while line is valid and not taken, the whole pipeline holds and
//   item.ready is low; otherwise item.ready is high, bubbles included.
// Reset: rst, synchronous, empties the pipeline and drops line.valid; the
//   block takes items in the first cycle after reset.
module gradient_fill_line_generator (
  input  logic      clk,
  input  logic      rst,
  gfl_in_if.sink    item,
  gfl_out_if.source line
);

  logic                                 en;
  logic [gfl_pkg::NUM_CELLS:0]          vld;
  gfl_pkg::stage_t                      st [gfl_pkg::NUM_CELLS+1];
  gfl_pkg::stage_t                      last;
  logic [gfl_pkg::NUM_CH-1:0][gfl_pkg::CH_W-1:0] colour;

  assign en   = !line.valid || line.ready;
  assign last = st[gfl_pkg::NUM_CELLS];

  gfl_prep u_prep (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .item (item),
    .vld  (vld[0]),
    .st   (st[0])
  );

  for (genvar i = 0; i < gfl_pkg::NUM_CELLS; i++) begin : g_cell
    gfl_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_in (vld[i]),
      .st_in  (st[i]),
      .vld    (vld[i+1]),
      .st     (st[i+1])
    );
  end

  always_comb begin
    for (int c = 0; c < gfl_pkg::NUM_CH; c++) begin
      colour[c] = last.neg[c] ? last.base[c] - last.quo[c] : last.base[c] + last.quo[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line.valid <= 1'b0;
    end else if (en) begin
      line.valid <= vld[gfl_pkg::NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line.line_valid <= last.line_ok;
      line.line_x0    <= last.line_ok ? last.x0 : '0;
      line.line_y0    <= last.line_ok ? last.y0 : '0;
      line.line_x1    <= last.line_ok ? last.x1 : '0;
      line.line_y1    <= last.line_ok ? last.y1 : '0;
      line.red_out    <= last.line_ok ? colour[0] : '0;
      line.green_out  <= last.line_ok ? colour[1] : '0;
      line.blue_out   <= last.line_ok ? colour[2] : '0;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !line.valid)
    else $error("line beat present right after reset");

  a_last_cell_reaches_out: assert property (@(posedge clk) disable iff (rst)
    vld[gfl_pkg::NUM_CELLS] && en |=> line.valid)
    else $error("beat from last cell lost");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    line.valid && !line.line_valid |-> line.line_x0 == '0 && line.line_y0 == '0 &&
      line.line_x1 == '0 && line.line_y1 == '0 && line.red_out == '0 &&
      line.green_out == '0 && line.blue_out == '0)
    else $error("missing line carries non-zero fields");

  a_stall_holds_ready: assert property (@(posedge clk) disable iff (rst)
    line.valid && !line.ready |-> !item.ready)
    else $error("item taken while pipeline stalled");

endmodule
